>>> sv/rss_pkg.sv
// rss_pkg: shared types, sizes and the microcode table of the record sorter
// depends on nothing; used by the channel interfaces, the sequencer and the top level
package rss_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int KEY_W       = 32;
  localparam int PAYLOAD_W   = 16;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAYLOAD_W-1:0]    payload;
  } rec_t;

  // microprogram addresses
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OUTER,
    ST_LDBEST,
    ST_SCAN,
    ST_SWAP_LO,
    ST_SWAP_HI,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD,
    ST_EMIT_NEXT,
    ST_DONE
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_FINAL,
    C_OUTER_DONE,
    C_SCAN_DONE,
    C_EMIT_MORE
  } cond_t;

  // fall-through behavior when the jump is not taken
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_STAY,
    SEQ_WAIT_ACK
  } seq_t;

  typedef enum logic [1:0] {
    RD_I,
    RD_J,
    RD_J_NEXT,
    RD_K
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_LOAD,
    WR_AT_I,
    WR_AT_BEST
  } wr_sel_t;

  typedef struct packed {
    step_t   tgt;
    cond_t   cond;
    seq_t    seq;
    rd_sel_t rd;
    wr_sel_t wr;
    logic    in_rdy;
    logic    ptr_clr;
    logic    pass_init;
    logic    cap;
    logic    cmp;
    logic    j_inc;
    logic    i_inc;
    logic    k_inc;
    logic    out_load;
    logic    cnt_clr;
  } uword_t;

  // status flags fed back from the datapath to the sequencer
  typedef struct packed {
    logic final_acc;
    logic outer_done;
    logic scan_done;
    logic emit_more;
    logic out_ack;
  } rss_stat_t;

  // control store
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '0;
    case (s)
      ST_IDLE: begin
        w.in_rdy  = 1'b1;
        w.ptr_clr = 1'b1;
        w.wr      = WR_LOAD;
        w.cond    = C_FINAL;
        w.tgt     = ST_OUTER;
        w.seq     = SEQ_STAY;
      end
      ST_OUTER: begin
        w.pass_init = 1'b1;
        w.rd        = RD_I;
        w.cond      = C_OUTER_DONE;
        w.tgt       = ST_EMIT_RD;
      end
      ST_LDBEST: begin
        w.cap = 1'b1;
        w.rd  = RD_J;
      end
      ST_SCAN: begin
        w.cmp   = 1'b1;
        w.j_inc = 1'b1;
        w.rd    = RD_J_NEXT;
        w.cond  = C_SCAN_DONE;
        w.tgt   = ST_SWAP_LO;
        w.seq   = SEQ_STAY;
      end
      ST_SWAP_LO: begin
        w.wr = WR_AT_I;
      end
      ST_SWAP_HI: begin
        w.wr    = WR_AT_BEST;
        w.i_inc = 1'b1;
        w.cond  = C_ALWAYS;
        w.tgt   = ST_OUTER;
      end
      ST_EMIT_RD: begin
        w.rd = RD_K;
      end
      ST_EMIT_LD: begin
        w.out_load = 1'b1;
      end
      ST_EMIT_HOLD: begin
        w.seq = SEQ_WAIT_ACK;
      end
      ST_EMIT_NEXT: begin
        w.k_inc = 1'b1;
        w.cond  = C_EMIT_MORE;
        w.tgt   = ST_EMIT_RD;
      end
      ST_DONE: begin
        w.cnt_clr = 1'b1;
        w.cond    = C_ALWAYS;
        w.tgt     = ST_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.tgt  = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> sv/rss_in_if.sv
// rss_in_if: request channel carrying one record into the sorter
// depends on rss_pkg for field widths
interface rss_in_if
  import rss_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key;
  logic [PAYLOAD_W-1:0]    payload;
  logic                    final_record;

  modport source (output valid, key, payload, final_record, input ready);
  modport sink   (input valid, key, payload, final_record, output ready);
endinterface

>>> sv/rss_out_if.sv
// rss_out_if: request channel carrying one sorted record out of the sorter
// depends on rss_pkg for field widths
interface rss_out_if
  import rss_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] sorted_key;
  logic [PAYLOAD_W-1:0]    sorted_payload;
  logic                    last_out;

  modport source (output valid, sorted_key, sorted_payload, last_out, input ready);
  modport sink   (input valid, sorted_key, sorted_payload, last_out, output ready);
endinterface

>>> sv/rss_useq.sv
// rss_useq: microprogram sequencer, step counter plus control store lookup
// depends on rss_pkg for the control word, status flags and the program
module rss_useq
  import rss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  rss_stat_t stat,
  output uword_t    uw
);

  step_t pc_r, pc_nxt;
  logic  hit;

  assign uw = ucode(pc_r);

  always_comb begin
    case (uw.cond)
      C_NONE:       hit = 1'b0;
      C_ALWAYS:     hit = 1'b1;
      C_FINAL:      hit = stat.final_acc;
      C_OUTER_DONE: hit = stat.outer_done;
      C_SCAN_DONE:  hit = stat.scan_done;
      C_EMIT_MORE:  hit = stat.emit_more;
      default:      hit = 1'b0;
    endcase

    if (hit) begin
      pc_nxt = uw.tgt;
    end else begin
      case (uw.seq)
        SEQ_NEXT:     pc_nxt = step_t'(pc_r + 4'd1);
        SEQ_STAY:     pc_nxt = pc_r;
        SEQ_WAIT_ACK: pc_nxt = stat.out_ack ? step_t'(pc_r + 4'd1) : pc_r;
        default:      pc_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> sv/record_selection_sort.sv
// record_selection_sort: top level, record memory, sort datapath and channel handling
// depends on rss_pkg, rss_in_if, rss_out_if and rss_useq
//
// Records (signed key plus payload tag) are loaded one per cycle into a
// 64-entry record memory while the block is idle; records past capacity are
// dropped. A request with final_record set starts a selection sort in the
// order chosen by cfg_wdata (0 ascending, 1 descending), after which every
// held record is sent out in sorted order with last_out on the last one, and
// the store is emptied for the next set. Input ready is low from the final
// request until the last sorted record has been taken and the closing steps
// ST_EMIT_NEXT and ST_DONE have run. The memory has one read port, so each
// pass compares one record per cycle after the setup steps ST_OUTER and
// ST_LDBEST, then swaps in ST_SWAP_LO and ST_SWAP_HI; a last ST_OUTER sees
// that the passes are done. Each record is emitted through ST_EMIT_RD,
// ST_EMIT_LD and ST_EMIT_HOLD, which waits for the consumer to take it, and
// ST_EMIT_NEXT; ST_DONE then empties the store. Among equal keys the earliest
// candidate in a pass wins, so equal keys may not keep their arrival order.
module record_selection_sort
  import rss_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  rss_in_if.sink    in_req,
  rss_out_if.source out_req,
  input  logic  cfg_we,
  input  logic  cfg_wdata
);

  // sequencer
  uword_t    uw;
  rss_stat_t stat;

  rss_useq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .uw   (uw)
  );

  // config
  logic descending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      descending_r <= 1'b0;
    end else if (cfg_we) begin
      descending_r <= cfg_wdata;
    end
  end

  // counters and pointers
  logic [CNT_W-1:0] count_r, i_r, j_r, k_r;
  logic [IDX_W-1:0] best_r;
  rec_t             best_rec_r, i_rec_r;

  logic [CNT_W:0]   i_plus, j_plus, k_plus;
  logic             in_acc, full, out_ack, worse;

  assign in_acc  = in_req.valid && in_req.ready;
  assign full    = count_r >= CNT_W'(MAX_RECORDS);
  assign i_plus  = {1'b0, i_r} + 1'b1;
  assign j_plus  = {1'b0, j_r} + 1'b1;
  assign k_plus  = {1'b0, k_r} + 1'b1;
  assign out_ack = out_req.valid && out_req.ready;

  // record memory, one write port and one registered read port
  rec_t             mem [MAX_RECORDS];
  rec_t             rd_q;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  rec_t             wr_data;
  logic             wr_en;

  always_comb begin
    case (uw.rd)
      RD_I:      rd_addr = i_r[IDX_W-1:0];
      RD_J:      rd_addr = j_r[IDX_W-1:0];
      RD_J_NEXT: rd_addr = j_plus[IDX_W-1:0];
      RD_K:      rd_addr = k_r[IDX_W-1:0];
      default:   rd_addr = '0;
    endcase

    wr_en   = 1'b0;
    wr_addr = count_r[IDX_W-1:0];
    wr_data = best_rec_r;
    case (uw.wr)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_LOAD: begin
        wr_en           = in_acc && !full;
        wr_addr         = count_r[IDX_W-1:0];
        wr_data.key     = in_req.key;
        wr_data.payload = in_req.payload;
      end
      WR_AT_I: begin
        wr_en   = 1'b1;
        wr_addr = i_r[IDX_W-1:0];
        wr_data = best_rec_r;
      end
      WR_AT_BEST: begin
        wr_en   = 1'b1;
        wr_addr = best_r;
        wr_data = i_rec_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // candidate key loses to the key just read
  assign worse = descending_r ? ($signed(best_rec_r.key) < $signed(rd_q.key))
                              : ($signed(best_rec_r.key) > $signed(rd_q.key));

  // status back to the sequencer
  assign stat.final_acc  = in_acc && in_req.final_record;
  assign stat.outer_done = i_plus >= {1'b0, count_r};
  assign stat.scan_done  = j_plus >= {1'b0, count_r};
  assign stat.emit_more  = k_plus <  {1'b0, count_r};
  assign stat.out_ack    = out_ack;

  // sort datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      if (uw.cnt_clr) begin
        count_r <= '0;
      end else if (uw.wr == WR_LOAD && in_acc && !full) begin
        count_r <= count_r + 1'b1;
      end

      if (uw.ptr_clr) begin
        i_r <= '0;
        k_r <= '0;
      end else begin
        if (uw.i_inc) i_r <= i_plus[CNT_W-1:0];
        if (uw.k_inc) k_r <= k_plus[CNT_W-1:0];
      end

      // scan starts one past the pass position
      if (uw.pass_init) begin
        j_r <= i_plus[CNT_W-1:0];
      end else if (uw.j_inc) begin
        j_r <= j_plus[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uw.pass_init) begin
      best_r <= i_r[IDX_W-1:0];
    end else if (uw.cmp && worse) begin
      best_r <= j_r[IDX_W-1:0];
    end

    if (uw.cap) begin
      best_rec_r <= rd_q;
      i_rec_r    <= rd_q;
    end else if (uw.cmp && worse) begin
      best_rec_r <= rd_q;
    end
  end

  // output register
  logic                    out_valid_r;
  logic signed [KEY_W-1:0] out_key_r;
  logic [PAYLOAD_W-1:0]    out_payload_r;
  logic                    out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uw.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ack) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.out_load) begin
      out_key_r     <= rd_q.key;
      out_payload_r <= rd_q.payload;
      out_last_r    <= k_plus == {1'b0, count_r};
    end
  end

  assign in_req.ready           = uw.in_rdy;
  assign out_req.valid          = out_valid_r;
  assign out_req.sorted_key     = out_key_r;
  assign out_req.sorted_payload = out_payload_r;
  assign out_req.last_out       = out_last_r;

  // checks
  a_no_load_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !uw.in_rdy)
    else $error("input taken while a sorted record is pending");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond capacity");

  a_final_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready && in_req.final_record) |=> !in_req.ready)
    else $error("input still open after the final record");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    uw.cmp |-> (j_r < count_r))
    else $error("scan pointer past the held records");

endmodule
